FILE: src/mli_pkg.sv
`default_nettype none
package mli_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int CHAN_W       = 4;
	localparam int SMP_W        = 16;
	localparam int COEF_W       = 16;

	typedef logic [CHAN_W-1:0]        chan_t;
	typedef logic signed [SMP_W-1:0]  sample_t;
	typedef logic [COEF_W-1:0]        coef_t;

	typedef enum logic {
		FUNC_FILTER = 1'b0,
		FUNC_LOAD   = 1'b1
	} func_t;

	typedef struct packed {
		coef_t   decay;
		sample_t lvl_real;
		sample_t lvl_imag;
	} entry_t;

endpackage
`default_nettype wire

FILE: src/mli_if.sv
`default_nettype none
interface mli_item_if;
	logic            valid;
	logic            ready;
	logic            func;
	mli_pkg::chan_t  channel;
	logic            start_req;
	mli_pkg::sample_t in_real;
	mli_pkg::sample_t in_imag;
	mli_pkg::coef_t  coef;

	modport source (
		output valid, func, channel, start_req, in_real, in_imag, coef,
		input  ready
	);
	modport sink (
		input  valid, func, channel, start_req, in_real, in_imag, coef,
		output ready
	);
endinterface

interface mli_result_if;
	logic             valid;
	logic             ready;
	mli_pkg::chan_t   out_channel;
	mli_pkg::sample_t out_real;
	mli_pkg::sample_t out_imag;

	modport source (
		output valid, out_channel, out_real, out_imag,
		input  ready
	);
	modport sink (
		input  valid, out_channel, out_real, out_imag,
		output ready
	);
endinterface
`default_nettype wire

FILE: src/multichannel_leaky_integrator.sv
// Per-channel first-order leaky integrator, y = a*y_prev + (1-a)*x on the real part and,
// with complex mode set via cfg_wr_en, on the imaginary part (else zero); Q1.15 samples,
// a Q0.16 decay per channel, round-to-nearest. A load beat (func 1) stores the decay of a
// channel and gives no result; a filter beat gives one result; a beat for a channel at or
// beyond CHANNELS is dropped. The block takes one beat per cycle unless the result side
// stalls: a beat reads its channel entry from a one-read one-write RAM in the cycle it is
// accepted, is updated in the next cycle and written back as it leaves stage one, with
// forwarding when the following beat hits the same channel; a filter result is registered
// as its beat leaves stage one. State is all zero after reset without any clearing pass.
`default_nettype none
module multichannel_leaky_integrator #(
	parameter int CHANNELS = mli_pkg::CHANNELS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_wr_en,
	input  wire logic     cfg_wr_data,
	mli_item_if.sink      item,
	mli_result_if.source  result
);

	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMP_W = mli_pkg::CHAN_W + AW + 1;
	localparam int EW    = $bits(mli_pkg::entry_t);

	logic complex_enable_q;

	logic             accept;
	logic [CMP_W-1:0] in_chan_w;
	logic [AW-1:0]    in_addr;
	logic             in_range;

	logic             valid_s1;
	logic             func_s1;
	logic [AW-1:0]    addr_s1;
	mli_pkg::chan_t   chan_s1;
	logic             range_s1;
	logic             start_s1;
	mli_pkg::sample_t real_s1;
	mli_pkg::sample_t imag_s1;
	mli_pkg::coef_t   coef_s1;
	logic             hit_s1;
	logic             byp_s1;
	mli_pkg::entry_t  byp_data_s1;

	logic [CHANNELS-1:0] written_q;

	logic [EW-1:0]    ram_rdata;
	mli_pkg::entry_t  cur;
	mli_pkg::sample_t prev_real;
	mli_pkg::sample_t prev_imag;
	mli_pkg::sample_t leak_real;
	mli_pkg::sample_t leak_imag;
	mli_pkg::sample_t new_imag;

	logic             emit_s1;
	logic             adv_s1;
	logic             wr_en;
	mli_pkg::entry_t  wr_data;

	logic             out_valid_q;
	mli_pkg::chan_t   out_channel_q;
	mli_pkg::sample_t out_real_q;
	mli_pkg::sample_t out_imag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complex_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			complex_enable_q <= cfg_wr_data;
		end
	end

	assign accept    = item.valid && item.ready;
	assign in_chan_w = CMP_W'(item.channel);
	assign in_addr   = in_chan_w[AW-1:0];
	assign in_range  = in_chan_w < CMP_W'(CHANNELS);

	assign emit_s1    = valid_s1 && range_s1 && (func_s1 == mli_pkg::FUNC_FILTER);
	assign adv_s1     = valid_s1 && (!emit_s1 || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv_s1;

	mli_ram #(
		.WIDTH (EW),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (byp_s1) begin
			cur = byp_data_s1;
		end else if (hit_s1) begin
			cur = mli_pkg::entry_t'(ram_rdata);
		end else begin
			cur = '0;
		end
	end

	assign prev_real = start_s1 ? '0 : cur.lvl_real;
	assign prev_imag = start_s1 ? '0 : cur.lvl_imag;

	mli_leak u_leak_real (
		.decay (cur.decay),
		.prev  (prev_real),
		.x     (real_s1),
		.y     (leak_real)
	);

	mli_leak u_leak_imag (
		.decay (cur.decay),
		.prev  (prev_imag),
		.x     (imag_s1),
		.y     (leak_imag)
	);

	assign new_imag = complex_enable_q ? leak_imag : '0;

	assign wr_en = adv_s1 && range_s1;

	always_comb begin
		wr_data = cur;
		if (func_s1 == mli_pkg::FUNC_LOAD) begin
			wr_data.decay = coef_s1;
		end else begin
			wr_data.lvl_real = leak_real;
			wr_data.lvl_imag = new_imag;
		end
	end

	// advance stage one; forward the write-back when the next beat hits the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= item.func;
			addr_s1     <= in_addr;
			chan_s1     <= item.channel;
			range_s1    <= in_range;
			start_s1    <= item.start_req;
			real_s1     <= item.in_real;
			imag_s1     <= item.in_imag;
			coef_s1     <= item.coef;
			hit_s1      <= in_range && written_q[in_addr];
			byp_s1      <= wr_en && (addr_s1 == in_addr);
			byp_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			out_channel_q <= chan_s1;
			out_real_q    <= leak_real;
			out_imag_q    <= new_imag;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_channel = out_channel_q;
	assign result.out_real    = out_real_q;
	assign result.out_imag    = out_imag_q;

	a_emit_loads_out : assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emit_s1 |=> out_valid_q)
		else $error("filtered beat did not reach the result register");

	a_out_no_drop : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q)
		else $error("pending result dropped while stalled");

	a_s1_hold : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(addr_s1) && $stable(func_s1))
		else $error("stage one changed while blocked");

	a_pass_through : assert property (@(posedge clk) disable iff (!arst_n)
		emit_s1 && (cur.decay == '0) |-> leak_real == real_s1)
		else $error("zero decay did not pass the sample through");

endmodule
`default_nettype wire

FILE: src/mli_ram.sv
`default_nettype none
module mli_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/mli_leak.sv
`default_nettype none
module mli_leak (
	input  wire mli_pkg::coef_t   decay,
	input  wire mli_pkg::sample_t prev,
	input  wire mli_pkg::sample_t x,
	output      mli_pkg::sample_t y
);

	// a*prev + (1-a)*x == x*2^16 + a*(prev - x)
	logic signed [16:0] diff;
	logic signed [16:0] a_s;
	logic signed [33:0] prod;
	logic signed [33:0] x_sh;
	logic signed [33:0] sum;

	assign diff = {prev[15], prev} - {x[15], x};
	assign a_s  = {1'b0, decay};
	assign prod = diff * a_s;
	assign x_sh = {{2{x[15]}}, x, 16'h0000};
	assign sum  = x_sh + prod + 34'sd32768;
	assign y    = sum[31:16];

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mli_pkg::*;

	localparam longint UNITY = 65536;
	localparam int     TAIL  = 4;

	typedef struct {
		func_t   func;
		chan_t   ch;
		logic    st;
		sample_t re;
		sample_t im;
		coef_t   cf;
	} beat_t;

	typedef struct {
		chan_t   ch;
		sample_t re;
		sample_t im;
	} level_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en   = 1'b0;
	logic cfg_wr_data = 1'b0;

	mli_item_if   item_bus ();
	mli_result_if res_bus ();

	multichannel_leaky_integrator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item_bus),
		.result      (res_bus)
	);

	beat_t   pend_q[$];
	level_t  level_q[$];
	coef_t   decay_mem [CHANNELS_DEF] = '{default: '0};
	sample_t lvl_re    [CHANNELS_DEF] = '{default: '0};
	sample_t lvl_im    [CHANNELS_DEF] = '{default: '0};
	bit      cplx_en = 1'b0;
	bit      tx_calm = 1'b0;
	bit      rx_calm = 1'b0;
	int      err_cnt = 0;
	int      tx_gap  = 0;
	int      rx_stall = 0;
	chan_t   last_ch = '0;

	beat_t   nxt;
	bit      hold_beat;
	coef_t   a_cur;
	sample_t prev_re;
	sample_t prev_im;
	level_t  got;
	level_t  want;

	function automatic sample_t leak_step(coef_t a, sample_t prev, sample_t x);
		longint acc;
		acc = longint'(a) * longint'(prev) + (UNITY - longint'(a)) * longint'(x);
		acc = acc + 32768;
		return sample_t'(acc >>> 16);
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t rnd_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return sample_t'($urandom());
		endcase
	endfunction

	function automatic coef_t rnd_coef();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3, 4, 5: return coef_t'($urandom_range(60000, 65535));
			default: return coef_t'($urandom());
		endcase
	endfunction

	function automatic beat_t mk(func_t f, chan_t c, logic s, sample_t r, sample_t i, coef_t k);
		beat_t b;
		b.func = f;
		b.ch   = c;
		b.st   = s;
		b.re   = r;
		b.im   = i;
		b.cf   = k;
		return b;
	endfunction

	task automatic flag_error(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic push_random(int n);
		beat_t b;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) < 3)
				b.ch = last_ch;
			else
				b.ch = chan_t'($urandom());
			last_ch = b.ch;
			b.func = ($urandom_range(0, 9) == 0) ? FUNC_LOAD : FUNC_FILTER;
			b.st   = ($urandom_range(0, 9) == 0);
			b.re   = rnd_sample();
			b.im   = rnd_sample();
			b.cf   = rnd_coef();
			pend_q.push_back(b);
		end
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (pend_q.size() != 0 || item_bus.valid || level_q.size() != 0);
		repeat (TAIL) @(negedge clk);
	endtask

	task automatic set_complex(bit v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cplx_en = v;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bus.valid     <= 1'b0;
			item_bus.func      <= 1'b0;
			item_bus.channel   <= '0;
			item_bus.start_req <= 1'b0;
			item_bus.in_real   <= '0;
			item_bus.in_imag   <= '0;
			item_bus.coef      <= '0;
			tx_gap = 0;
		end else begin
			hold_beat = item_bus.valid && !item_bus.ready;
			if (item_bus.valid && item_bus.ready) begin
				if (item_bus.func == FUNC_LOAD) begin
					decay_mem[item_bus.channel] = item_bus.coef;
				end else begin
					a_cur   = decay_mem[item_bus.channel];
					prev_re = item_bus.start_req ? '0 : lvl_re[item_bus.channel];
					prev_im = item_bus.start_req ? '0 : lvl_im[item_bus.channel];
					lvl_re[item_bus.channel] = leak_step(a_cur, prev_re, item_bus.in_real);
					lvl_im[item_bus.channel] =
						cplx_en ? leak_step(a_cur, prev_im, item_bus.in_imag) : '0;
					level_q.push_back('{item_bus.channel, lvl_re[item_bus.channel],
						lvl_im[item_bus.channel]});
				end
			end
			if (!hold_beat) begin
				if (tx_gap > 0) begin
					tx_gap--;
					item_bus.valid <= 1'b0;
				end else if (pend_q.size() != 0) begin
					nxt = pend_q.pop_front();
					item_bus.func      <= nxt.func;
					item_bus.channel   <= nxt.ch;
					item_bus.start_req <= nxt.st;
					item_bus.in_real   <= nxt.re;
					item_bus.in_imag   <= nxt.im;
					item_bus.coef      <= nxt.cf;
					item_bus.valid     <= 1'b1;
					tx_gap = pick_gap(tx_calm);
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				got = '{res_bus.out_channel, res_bus.out_real, res_bus.out_imag};
				if (level_q.size() == 0) begin
					flag_error($sformatf("unexpected beat ch=%0d re=%0d im=%0d",
						got.ch, got.re, got.im));
				end else begin
					want = level_q.pop_front();
					if (got.ch !== want.ch)
						flag_error($sformatf("out_channel exp %0d got %0d", want.ch, got.ch));
					if (got.re !== want.re)
						flag_error($sformatf("out_real ch=%0d exp %0d got %0d",
							want.ch, want.re, got.re));
					if (got.im !== want.im)
						flag_error($sformatf("out_imag ch=%0d exp %0d got %0d",
							want.ch, want.im, got.im));
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
				rx_stall = pick_gap(rx_calm);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pend_q.push_back(mk(FUNC_FILTER, 4'd0,  1'b0, 16'sh7FFF, 16'sh8000, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd15, 1'b1, 16'sh8000, 16'sh7FFF, 16'hFFFF));
		pend_q.push_back(mk(FUNC_LOAD,   4'd3,  1'b0, 16'sh1234, 16'sh4321, 16'hFFFF));
		pend_q.push_back(mk(FUNC_FILTER, 4'd3,  1'b1, 16'sh7FFF, 16'sh7FFF, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd3,  1'b0, 16'sh8000, 16'sh8000, 16'h0000));
		pend_q.push_back(mk(FUNC_LOAD,   4'd5,  1'b0, 16'sh0000, 16'sh0000, 16'h8000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd5,  1'b1, 16'sh8000, 16'sh8000, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd5,  1'b0, 16'sh8000, 16'sh8000, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd5,  1'b0, -16'sd1,   16'sh0001, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd5,  1'b0, 16'sh0001, -16'sd1,   16'h0000));
		settle();
		set_complex(1'b1);

		pend_q.push_back(mk(FUNC_FILTER, 4'd5,  1'b0, 16'sh7FFF, 16'sh8000, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd5,  1'b0, 16'sh7FFF, 16'sh8000, 16'h0000));
		pend_q.push_back(mk(FUNC_LOAD,   4'd5,  1'b0, 16'sh7FFF, 16'sh7FFF, 16'hC000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd5,  1'b0, 16'sh0000, 16'sh0000, 16'h0000));
		pend_q.push_back(mk(FUNC_LOAD,   4'd7,  1'b0, 16'sh0000, 16'sh0000, 16'h0001));
		pend_q.push_back(mk(FUNC_FILTER, 4'd7,  1'b1, 16'sh8000, 16'sh7FFF, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd7,  1'b0, 16'sh8000, 16'sh7FFF, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd15, 1'b0, 16'sh7FFF, 16'sh7FFF, 16'h0000));
		pend_q.push_back(mk(FUNC_LOAD,   4'd15, 1'b0, 16'sh0000, 16'sh0000, 16'hFFFF));
		pend_q.push_back(mk(FUNC_FILTER, 4'd15, 1'b1, 16'sh8000, 16'sh8000, 16'h0000));
		pend_q.push_back(mk(FUNC_FILTER, 4'd15, 1'b0, 16'sh7FFF, 16'sh7FFF, 16'h0000));
		settle();
		set_complex(1'b0);

		tx_calm = 1'b1;
		rx_calm = 1'b1;
		push_random(300);
		settle();
		set_complex(1'b1);

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		push_random(150);
		settle();
		push_random(150);
		settle();
		set_complex(1'b0);

		tx_calm = 1'b1;
		push_random(300);
		settle();
		set_complex(1'b1);

		tx_calm = 1'b0;
		push_random(300);
		settle();

		repeat (8) @(negedge clk);
		if (err_cnt == 0 && level_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
